// File: design/buzzer_tone_generator_defines.svh
// Assertion macros shared by the checking code of the buzzer tone generator.
`ifndef BUZZER_TONE_GENERATOR_DEFINES_SVH
`define BUZZER_TONE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BZT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BZT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/bzt_pkg.sv
package bzt_pkg;

   localparam int FREQ_W     = 16;
   localparam int DUR_W      = 16;
   localparam int TOTAL_W    = 26;
   localparam int HALF_W     = 19;
   localparam int PHASE_W    = 20;
   localparam int DIVIDEND_W = 26;
   localparam int DIVISOR_W  = 20;
   localparam int TPM_W      = 17;

   localparam int TICKS_PER_MS_DEFAULT        = 1000;
   localparam int HALF_WAVE_NUMERATOR_DEFAULT = 500000;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_TICK  = 1'b1
   } item_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WAIT_HALF,
      ST_START_WAVE,
      ST_WAIT_WAVE,
      ST_FINISH
   } seq_state_type;

   // Result of the shared divider, valid in the cycle that done is high.
   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_result_type;

endpackage

// File: design/bzt_divider.sv
module bzt_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bzt_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [bzt_pkg::DIVISOR_W-1:0]   divisor,
   output bzt_pkg::div_result_type         result
);
   import bzt_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  qbit;

   // Restoring division, one quotient bit per cycle. The quotient shifts
   // into the low end of the dividend register as the dividend leaves it.
   always_comb begin
      trial   = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      qbit    = (trial >= {1'b0, dvs_ff});
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIVIDEND_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], qbit};
         rem_in = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = dvd_ff;
   assign result.remainder = rem_ff;

endmodule

// File: design/buzzer_tone_generator.sv
// Square-wave tone generator for a buzzer pin. A start transaction carries a
// frequency in hertz and a duration in milliseconds; every tick transaction
// after it stands for one microsecond and returns the pin level for that
// microsecond, whether the tone is still running and whether this tick ended
// it. The half period is HALF_WAVE_NUMERATOR divided by the frequency, in
// whole microseconds; the pin is high in the first half of each period and
// low in the second, but only for as many whole periods as fit into the
// duration, after which it stays low until the duration has run out. A zero
// frequency (or one so high that the half period rounds to zero) gives
// silence, a zero duration finishes on the start transaction itself, and a
// start while a tone runs replaces it. Every transaction produces exactly one
// result transaction. A tick's result is registered and presented in the
// cycle after the tick is taken. A start makes two passes through the shared
// one-bit-per-clock restoring divider (half period first, then the last
// whole period that fits; a zero frequency skips both, a zero half period the
// second), plus a multiply and a finishing step; req_ready stays low
// throughout, as it does while an earlier result has not been taken.
module buzzer_tone_generator #(
   parameter int TICKS_PER_MS        = bzt_pkg::TICKS_PER_MS_DEFAULT,
   parameter int HALF_WAVE_NUMERATOR = bzt_pkg::HALF_WAVE_NUMERATOR_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [bzt_pkg::FREQ_W-1:0]  req_frequency_hz,
   input  logic [bzt_pkg::DUR_W-1:0]   req_duration_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_pin_level,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res
);
   import bzt_pkg::*;

   localparam int PROD_W = DUR_W + TPM_W;

   // Sequencer and tone state.
   seq_state_type        state_ff, state_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [HALF_W-1:0]    half_ff, half_in;
   logic [TOTAL_W-1:0]   wave_end_ff, wave_end_in;
   logic [TOTAL_W-1:0]   elapsed_ff, elapsed_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 running_ff, running_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pin_ff, rsp_pin_in;
   logic                 rsp_busy_ff, rsp_busy_in;
   logic                 rsp_done_ff, rsp_done_in;

   // Shared divider.
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   div_result_type        div_result;

   logic                  accept;
   logic [PROD_W-1:0]     product;
   logic [HALF_W-1:0]     half_sat;
   logic [PHASE_W-1:0]    period;
   logic [TOTAL_W-1:0]    elapsed_next;
   logic [PHASE_W:0]      phase_next;

   // A new transaction is taken only in idle, and only when the output
   // register is empty or is being emptied in this cycle.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Duration in microseconds: one multiply, saturated to the counter width.
   assign product = PROD_W'(dur_ff) * PROD_W'(TICKS_PER_MS);

   // Half period from the divider, saturated to its register width.
   assign half_sat = (div_result.quotient[DIVIDEND_W-1:HALF_W] != '0) ?
                     {HALF_W{1'b1}} : div_result.quotient[HALF_W-1:0];

   // Whole period in microseconds.
   assign period = {half_ff, 1'b0};

   // The divider is loaded from one of two operand pairs: the numerator over
   // the frequency for the half period, then the total time over the period,
   // whose remainder trims the total down to the last whole period.
   always_comb begin
      if (state_ff == ST_LOAD) begin
         div_dividend = DIVIDEND_W'(HALF_WAVE_NUMERATOR);
         div_divisor  = DIVISOR_W'(freq_ff);
      end else begin
         div_dividend = total_ff;
         div_divisor  = period;
      end
   end

   assign elapsed_next = elapsed_ff + 1'b1;
   assign phase_next   = {1'b0, phase_ff} + 1'b1;

   always_comb begin
      state_in     = state_ff;
      freq_in      = freq_ff;
      dur_in       = dur_ff;
      total_in     = total_ff;
      half_in      = half_ff;
      wave_end_in  = wave_end_ff;
      elapsed_in   = elapsed_ff;
      phase_in     = phase_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pin_in   = rsp_pin_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_done_in  = rsp_done_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_START) begin
                  freq_in  = req_frequency_hz;
                  dur_in   = req_duration_ms;
                  state_in = ST_LOAD;
               end else begin
                  // One microsecond of the running tone. An idle tick
                  // returns all zeros.
                  rsp_valid_in = 1'b1;
                  rsp_pin_in   = 1'b0;
                  rsp_done_in  = 1'b0;
                  if (running_ff) begin
                     rsp_pin_in = (elapsed_ff < wave_end_ff) &&
                                  (phase_ff < PHASE_W'(half_ff));
                     elapsed_in = elapsed_next;
                     if (phase_next >= {1'b0, period}) begin
                        phase_in = '0;
                     end else begin
                        phase_in = phase_next[PHASE_W-1:0];
                     end
                     if (elapsed_next >= total_ff) begin
                        rsp_done_in = 1'b1;
                        running_in  = 1'b0;
                     end
                  end
                  rsp_busy_in = running_in;
               end
            end
         end
         ST_LOAD: begin
            if (product[PROD_W-1:TOTAL_W] != '0) begin
               total_in = {TOTAL_W{1'b1}};
            end else begin
               total_in = product[TOTAL_W-1:0];
            end
            if (freq_ff == '0) begin
               // Silence: no half period and no whole periods.
               half_in     = '0;
               wave_end_in = '0;
               state_in    = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT_HALF;
            end
         end
         ST_WAIT_HALF: begin
            if (div_result.done) begin
               half_in = half_sat;
               if (half_sat == '0) begin
                  // Frequency above the numerator: treated as silence.
                  wave_end_in = '0;
                  state_in    = ST_FINISH;
               end else begin
                  state_in = ST_START_WAVE;
               end
            end
         end
         ST_START_WAVE: begin
            div_start = 1'b1;
            state_in  = ST_WAIT_WAVE;
         end
         ST_WAIT_WAVE: begin
            if (div_result.done) begin
               wave_end_in = total_ff - TOTAL_W'(div_result.remainder);
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The output register was emptied when the start was taken.
            elapsed_in   = '0;
            phase_in     = '0;
            running_in   = (total_ff != '0);
            rsp_valid_in = 1'b1;
            rsp_pin_in   = 1'b0;
            rsp_busy_in  = (total_ff != '0);
            rsp_done_in  = (total_ff == '0);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      freq_ff     <= freq_in;
      dur_ff      <= dur_in;
      total_ff    <= total_in;
      half_ff     <= half_in;
      wave_end_ff <= wave_end_in;
      elapsed_ff  <= elapsed_in;
      phase_ff    <= phase_in;
      rsp_pin_ff  <= rsp_pin_in;
      rsp_busy_ff <= rsp_busy_in;
      rsp_done_ff <= rsp_done_in;
   end

   bzt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = rsp_pin_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_done_res  = rsp_done_ff;

endmodule

// File: design/bzt_checker.sv
`include "buzzer_tone_generator_defines.svh"

module bzt_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_kind,
   input  logic [bzt_pkg::FREQ_W-1:0]  req_frequency_hz,
   input  logic [bzt_pkg::DUR_W-1:0]   req_duration_ms,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_pin_level,
   input  logic                        rsp_busy_res,
   input  logic                        rsp_done_res
);
   import bzt_pkg::*;

   logic rsp_stall;
   logic req_taken;
   logic [FREQ_W+DUR_W:0] req_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_taken   = req_valid && req_ready;
   assign req_payload = {req_kind, req_frequency_hz, req_duration_ms};

   // A stalled result holds its value.
   `BZT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable({rsp_pin_level, rsp_busy_res, rsp_done_res}), "result changed while stalled")

   // A finished tone is never reported as still running.
   `BZT_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res, "done and busy together")

   // The pin is only driven high while a tone is in progress.
   `BZT_ASSERT_SAME(a_pin_in_tone, clock, reset, rsp_valid && rsp_pin_level, rsp_busy_res || rsp_done_res, "pin high outside a tone")

   // After a transaction is taken the block holds off until its result drains.
   `BZT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_taken, !req_ready || rsp_ready, "second transaction taken while result pending")

   // A tick transaction is answered in the very next cycle.
   `BZT_ASSERT_NEXT(a_tick_result, clock, reset, req_taken && req_payload[FREQ_W+DUR_W] == KIND_TICK, rsp_valid, "tick gave no result")

endmodule

bind buzzer_tone_generator bzt_checker u_bzt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_kind         (req_kind),
   .req_frequency_hz (req_frequency_hz),
   .req_duration_ms  (req_duration_ms),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pin_level    (rsp_pin_level),
   .rsp_busy_res     (rsp_busy_res),
   .rsp_done_res     (rsp_done_res)
);

// File: bench/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the buzzer tone generator. An initial block queues
// every request transaction up front; a clocked driver offers them one at a
// time with random gaps, and a clocked monitor takes the result transactions
// with random stalls. It compares each one against the tone model kept here.
module tb;
   import bzt_pkg::*;

   // The block is built with its default parameters, so the model uses them too.
   localparam longint unsigned MS_TICKS  = TICKS_PER_MS_DEFAULT;
   localparam longint unsigned HALF_NUM  = HALF_WAVE_NUMERATOR_DEFAULT;
   localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 1;
   localparam longint unsigned HALF_MAX  = (64'd1 << HALF_W) - 1;

   localparam int RANDOM_ITEMS  = 1700;
   localparam int QUIET_LIMIT   = 2000; // cycles without any transaction
   localparam int HOLD_AT       = 400;  // result count at which the long stall begins
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 100;

   typedef struct packed {
      item_kind_type     kind;
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } tone_req_type;

   typedef struct packed {
      logic pin;
      logic busy;
      logic done;
   } tone_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_kind = KIND_START;
   logic [FREQ_W-1:0] req_frequency_hz = '0;
   logic [DUR_W-1:0]  req_duration_ms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_pin_level;
   logic              rsp_busy_res;
   logic              rsp_done_res;

   buzzer_tone_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_frequency_hz (req_frequency_hz),
      .req_duration_ms  (req_duration_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pin_level    (rsp_pin_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res)
   );

   always #5 clock = ~clock;

   tone_req_type pending_reqs[$];
   tone_rsp_type expected_rsps[$];

   // Tone state as the block should hold it. The declarations give the reset
   // values, and reset is asserted only once, so no separate clearing is needed.
   logic [TOTAL_W-1:0] tone_elapsed  = '0;
   logic [TOTAL_W-1:0] tone_total    = '0;
   logic [TOTAL_W-1:0] tone_wave_end = '0;
   logic [HALF_W-1:0]  tone_half     = '0;
   logic [PHASE_W-1:0] tone_phase    = '0;
   logic               tone_running  = 1'b0;

   int mismatch_count = 0;
   int queued_count   = 0;
   int sent_count     = 0;
   int start_count    = 0;
   int rsp_count      = 0;
   int done_count     = 0;
   int pin_high_count = 0;
   int quiet_cycles   = 0;
   int send_gap       = 0;
   int recv_gap       = 0;
   int hold_left      = 0;
   bit send_burst     = 1'b0;
   bit recv_burst     = 1'b0;

   // Moves the tone state on by one request transaction and returns the result
   // that the block must give for it.
   function automatic tone_rsp_type advance_tone(tone_req_type r);
      tone_rsp_type    o;
      longint unsigned tot;
      longint unsigned halfw;
      longint unsigned period;
      o = '0;
      if (r.kind == KIND_START) begin
         tot = longint'(r.dur) * MS_TICKS;
         if (tot > TOTAL_MAX) tot = TOTAL_MAX;
         halfw = (r.freq != 0) ? HALF_NUM / r.freq : 0;
         if (halfw > HALF_MAX) halfw = HALF_MAX;
         tone_total   = tot[TOTAL_W-1:0];
         tone_half    = halfw[HALF_W-1:0];
         tone_elapsed = '0;
         tone_phase   = '0;
         // The square wave only runs over the whole periods that fit; the
         // remainder of the duration is silent.
         period        = halfw * 2;
         tone_wave_end = (period != 0) ? TOTAL_W'((tot / period) * period) : '0;
         tone_running  = (tone_total != 0);
         o.done        = !tone_running;
      end else if (tone_running) begin
         o.pin        = (tone_elapsed < tone_wave_end) && (tone_phase < tone_half);
         tone_elapsed = tone_elapsed + 1'b1;
         tone_phase   = tone_phase + 1'b1;
         if (tone_phase >= 2 * tone_half) tone_phase = '0;
         if (tone_elapsed >= tone_total) begin
            o.done       = 1'b1;
            tone_running = 1'b0;
         end
      end
      o.busy = tone_running;
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, rsp_count, msg);
      mismatch_count++;
   endtask

   task automatic add_start(logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur);
      pending_reqs.push_back('{kind: KIND_START, freq: freq, dur: dur});
      queued_count++;
   endtask

   // The frequency and duration fields of a tick are ignored, so they carry
   // random values to toggle every request bit.
   task automatic add_ticks(int n);
      repeat (n) begin
         pending_reqs.push_back('{kind: KIND_TICK, freq: FREQ_W'($urandom),
                                  dur: DUR_W'($urandom)});
         queued_count++;
      end
   endtask

   // Frequencies are weighted towards half periods that fit a millisecond
   // many times over, with some that do not fit at all, and silence.
   function automatic logic [FREQ_W-1:0] pick_freq();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return FREQ_W'($urandom_range(1, 50));
         2, 3, 4, 5: return FREQ_W'($urandom_range(1000, 65535));
         6, 7:       return FREQ_W'($urandom_range(100, 999));
         default:    return FREQ_W'($urandom);
      endcase
   endfunction

   // Driver: offers the head of the queue, keeps it steady until it is taken,
   // and predicts the result at the moment of acceptance.
   always @(posedge clock) begin
      tone_rsp_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = advance_tone(pending_reqs[0]);
            expected_rsps.push_back(predicted);
            if (pending_reqs[0].kind == KIND_START) start_count++;
            done_count     += predicted.done;
            pin_high_count += predicted.pin;
            pending_reqs.pop_front();
            sent_count++;
            // Now and then switch between back-to-back bursts and random gaps.
            if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : int'($urandom_range(0, 8));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid        <= 1'b1;
               req_kind         <= pending_reqs[0].kind;
               req_frequency_hz <= pending_reqs[0].freq;
               req_duration_ms  <= pending_reqs[0].dur;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes result transactions after a random wait, once holding off
   // long enough for the block to fill and stall its input, and checks each
   // one against the oldest prediction.
   always @(posedge clock) begin
      tone_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("result transaction with nothing outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_pin_level !== want.pin)
                  report_mismatch($sformatf("pin_level %b, wanted %b", rsp_pin_level, want.pin));
               if (rsp_busy_res !== want.busy)
                  report_mismatch($sformatf("busy_res %b, wanted %b", rsp_busy_res, want.busy));
               if (rsp_done_res !== want.done)
                  report_mismatch($sformatf("done_res %b, wanted %b", rsp_done_res, want.done));
            end
            rsp_count++;
            if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
            recv_gap = recv_burst ? 0 : int'($urandom_range(0, 8));
            if (rsp_count == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
      bit                full_run;
      int                directed_count;

      // Directed part. A tick before any tone must be silent and idle.
      add_ticks(1);
      // Zero duration finishes on the start itself.
      add_start('1, '0);
      add_ticks(1);
      // Silence: the pin stays low, yet the block reports busy.
      add_start('0, 16'd1);
      add_ticks(2);
      // Extremes of both fields, the shortest half period first.
      add_start('1, '1);
      add_ticks(3);
      // Restart while busy, with the longest half period the fields allow.
      add_start(16'd1, '1);
      add_ticks(2);
      add_start(16'h8000, 16'd1);
      add_ticks(3);
      add_start('0, '0);
      add_ticks(1);
      add_start(16'h5555, 16'hAAAA);
      add_ticks(1);
      add_start(16'hAAAA, 16'h5555);
      add_ticks(1);
      directed_count = queued_count;

      // Random part: mostly a start followed by ticks. A few tones run to
      // their end, the first of them with a period that leaves a silent tail;
      // the rest are cut short by the next start.
      full_run = 1'b1;
      while (queued_count < directed_count + RANDOM_ITEMS) begin
         freq = pick_freq();
         case ($urandom_range(0, 19))
            0, 1, 2: dur = '0;
            16, 17:  dur = DUR_W'($urandom_range(2, 5));
            18, 19:  dur = DUR_W'($urandom);
            default: dur = 16'd1;
         endcase
         if (full_run) begin
            freq = 16'd3000;
            dur  = 16'd1;
         end else begin
            full_run = (dur == 16'd1) && ($urandom_range(0, 24) == 0);
         end
         add_start(freq, dur);
         if (full_run)
            add_ticks(int'(dur) * int'(MS_TICKS) + int'($urandom_range(1, 4)));
         else
            add_ticks(int'($urandom_range(0, 150)));
         full_run = 1'b0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      // Any stray result transaction would show up in this quiet stretch.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d transactions (%0d starts, %0d ticks), checked %0d results.",
               sent_count, start_count, sent_count - start_count, rsp_count);
      $display("Tones ended %0d times; the pin was high for %0d microseconds.",
               done_count, pin_high_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
